// ===== hdl/tmprof_pkg.sv =====
// ----------------------------------------------------------------------------
// tmprof_pkg
// Shared constants, control word type and microprogram for the trapezoidal
// motion profiler.
// ----------------------------------------------------------------------------
package tmprof_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int POS_WIDTH_DEF = 32;

  // time_step is Q0.16
  localparam int DT_FRAC = 16;
  localparam int TS_W    = 16;
  localparam logic [TS_W-1:0] TS_RESET = 16'd6554;

  // register map
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 1'b1;

  // microprogram steps
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_LOAD   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_BRAKE  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ACCEL  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_MULA   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_VEL    = 3'd4;
  localparam logic [STEP_W-1:0] STEP_MULV   = 3'd5;
  localparam logic [STEP_W-1:0] STEP_COMMIT = 3'd6;

  // multiplier operand selects
  localparam logic [1:0] MA_VEL  = 2'd0;
  localparam logic [1:0] MA_ACC  = 2'd1;
  localparam logic [1:0] MA_VTMP = 2'd2;
  localparam logic MB_VEL = 1'b0;
  localparam logic MB_TS  = 1'b1;

  // jump conditions
  localparam logic JC_NONE    = 1'b0;
  localparam logic JC_NO_TICK = 1'b1;

  typedef struct packed {
    logic [1:0]        mul_a;
    logic              mul_b;
    logic              mul_en;
    logic              ld_dist;
    logic              brake;
    logic              ld_acc;
    logic              ld_vtmp;
    logic              commit;
    logic              jcond;
    logic [STEP_W-1:0] jtarget;
  } ctrl_t;

  typedef struct packed {
    logic no_tick;
  } stat_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t cw;
    cw = '0;
    case (step)
      STEP_LOAD: begin
        cw.mul_a   = MA_VEL;
        cw.mul_b   = MB_VEL;
        cw.mul_en  = 1'b1;
        cw.ld_dist = 1'b1;
        cw.jcond   = JC_NO_TICK;
        cw.jtarget = STEP_COMMIT;
      end
      STEP_BRAKE: begin
        cw.brake = 1'b1;
      end
      STEP_ACCEL: begin
        cw.ld_acc = 1'b1;
      end
      STEP_MULA: begin
        cw.mul_a  = MA_ACC;
        cw.mul_b  = MB_TS;
        cw.mul_en = 1'b1;
      end
      STEP_VEL: begin
        cw.ld_vtmp = 1'b1;
      end
      STEP_MULV: begin
        cw.mul_a  = MA_VTMP;
        cw.mul_b  = MB_TS;
        cw.mul_en = 1'b1;
      end
      STEP_COMMIT: begin
        cw.commit = 1'b1;
      end
      default: begin
        cw.commit = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== hdl/tmprof_seq.sv =====
// ----------------------------------------------------------------------------
// tmprof_seq
// Step counter and microcode ROM; one word per cycle, commit may stall.
// ----------------------------------------------------------------------------
module tmprof_seq
  import tmprof_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  out_free,
  input  stat_t stat,
  output logic  busy,
  output ctrl_t cw
);

  logic [STEP_W-1:0] pc;
  ctrl_t             rom_word;

  assign rom_word = ucode(pc);

  // commit holds until the output word slot is free
  always_comb begin
    cw = '0;
    if (busy) begin
      cw        = rom_word;
      cw.commit = rom_word.commit & out_free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= STEP_LOAD;
    end else if (!busy) begin
      pc <= STEP_LOAD;
      if (start) begin
        busy <= 1'b1;
      end
    end else if (rom_word.commit) begin
      if (out_free) begin
        busy <= 1'b0;
      end
    end else if (rom_word.jcond == JC_NO_TICK && stat.no_tick) begin
      pc <= rom_word.jtarget;
    end else begin
      pc <= pc + STEP_W'(1);
    end
  end

endmodule

// ===== hdl/tmprof_dp.sv =====
// ----------------------------------------------------------------------------
// tmprof_dp
// Profile datapath: state, shared multiplier, clamps and output word.
// ----------------------------------------------------------------------------
module tmprof_dp
  import tmprof_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int POS_WIDTH = POS_WIDTH_DEF,
  localparam int VEL_W = FRAC_BITS + 4,
  localparam int ACC_W = FRAC_BITS + 2,
  localparam int CFG_W = (POS_WIDTH > TS_W) ? POS_WIDTH : TS_W
)
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        tick,
  input  ctrl_t                       cw,
  output stat_t                       stat,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  output logic signed [POS_WIDTH-1:0] position_out,
  output logic signed [VEL_W-1:0]     velocity_out,
  output logic signed [ACC_W-1:0]     accel_out,
  output logic                        braking,
  output logic                        at_rest
);

  localparam int MUL_W  = (VEL_W > TS_W + 1) ? VEL_W : TS_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DIST_W = POS_WIDTH + 1;
  localparam int STOP_W = FRAC_BITS + 4;
  localparam int CMP_W  = (DIST_W > STOP_W) ? DIST_W : STOP_W;
  localparam int ERR_W  = VEL_W + 1;
  localparam int SUM_W  = VEL_W + 2;
  localparam int PSUM_W = ((POS_WIDTH > SUM_W) ? POS_WIDTH : SUM_W) + 1;

  localparam int ONE_I      = 1 << FRAC_BITS;
  localparam int DEADBAND_I = (ONE_I + 5) / 10;
  localparam int NEAR_I     = (ONE_I + 50) / 100;

  localparam logic signed [VEL_W-1:0] MAX_SPD   = VEL_W'(5 * ONE_I);
  localparam logic signed [ERR_W-1:0] ACC_MAX_E = ERR_W'(ONE_I);
  localparam logic signed [ERR_W-1:0] ACC_MIN_E = -ERR_W'(2 * ONE_I);
  localparam logic [ERR_W-1:0]        DB_ERR    = ERR_W'(DEADBAND_I);
  localparam logic [VEL_W-1:0]        DB_VEL    = VEL_W'(DEADBAND_I);
  localparam logic [DIST_W-1:0]       NEAR_DIST = DIST_W'(NEAR_I);
  localparam logic signed [SUM_W-1:0] VSUM_HI   = SUM_W'(5 * ONE_I);
  localparam logic signed [SUM_W-1:0] VSUM_LO   = -VSUM_HI;
  localparam logic signed [PSUM_W-1:0] PSUM_HI  =
    PSUM_W'({1'b0, {(POS_WIDTH-1){1'b1}}});
  localparam logic signed [PSUM_W-1:0] PSUM_LO  = ~PSUM_HI;

  // architectural state
  logic signed [POS_WIDTH-1:0] pos;
  logic signed [VEL_W-1:0]     vel;
  logic signed [ACC_W-1:0]     acc;
  logic signed [VEL_W-1:0]     cruise;
  logic signed [POS_WIDTH-1:0] target;
  logic [TS_W-1:0]             ts;
  logic                        tick_reg;

  // scratch
  logic signed [DIST_W-1:0]    gap;
  logic signed [PROD_W-1:0]    prod;
  logic signed [VEL_W-1:0]     vtmp;

  logic signed [MUL_W-1:0]     ma;
  logic signed [MUL_W-1:0]     mb;
  logic [DIST_W-1:0]           dist_mag;
  logic [STOP_W-1:0]           stop;
  logic                        brake_hit;
  logic signed [ERR_W-1:0]     err;
  logic [ERR_W-1:0]            err_mag;
  logic signed [ERR_W-1:0]     acc_e;
  logic signed [SUM_W-1:0]     delta;
  logic signed [SUM_W-1:0]     vsum;
  logic signed [SUM_W-1:0]     vsat;
  logic signed [PSUM_W-1:0]    psum;
  logic signed [PSUM_W-1:0]    psat;
  logic [VEL_W-1:0]            vtmp_mag;
  logic                        snap;
  logic signed [POS_WIDTH-1:0] target_in;

  assign stat.no_tick = ~tick_reg;

  // shared multiplier operands
  always_comb begin
    case (cw.mul_a)
      MA_VEL:  ma = MUL_W'(vel);
      MA_ACC:  ma = MUL_W'(acc);
      MA_VTMP: ma = MUL_W'(vtmp);
      default: ma = '0;
    endcase
    if (cw.mul_b == MB_TS) begin
      mb = $signed(MUL_W'({1'b0, ts}));
    end else begin
      mb = MUL_W'(vel);
    end
  end

  // braking test: stop distance is v*v >> (FRAC_BITS+2)
  assign dist_mag  = gap[DIST_W-1] ? DIST_W'(-gap) : DIST_W'(gap);
  assign stop      = prod[FRAC_BITS+2 +: STOP_W];
  assign brake_hit = (gap != '0) && (CMP_W'(dist_mag) <= CMP_W'(stop));

  // speed error with deadband, clamped to +1 / -2
  assign err     = ERR_W'(cruise) - ERR_W'(vel);
  assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

  always_comb begin
    if (err_mag > DB_ERR) begin
      if (!err[ERR_W-1]) begin
        acc_e = (err < ACC_MAX_E) ? err : ACC_MAX_E;
      end else begin
        acc_e = (err > ACC_MIN_E) ? err : ACC_MIN_E;
      end
    end else begin
      acc_e = '0;
    end
  end

  // product >> DT_FRAC, floor; serves both integrations
  assign delta = prod[DT_FRAC +: SUM_W];

  assign vsum = SUM_W'(vel) + delta;
  always_comb begin
    if (vsum > VSUM_HI) begin
      vsat = VSUM_HI;
    end else if (vsum < VSUM_LO) begin
      vsat = VSUM_LO;
    end else begin
      vsat = vsum;
    end
  end

  assign psum = PSUM_W'(pos) + PSUM_W'(delta);
  always_comb begin
    if (psum > PSUM_HI) begin
      psat = PSUM_HI;
    end else if (psum < PSUM_LO) begin
      psat = PSUM_LO;
    end else begin
      psat = psum;
    end
  end

  // snap uses the pre-update distance and the saturated velocity
  assign vtmp_mag = vtmp[VEL_W-1] ? VEL_W'(-vtmp) : VEL_W'(vtmp);
  assign snap     = tick_reg && (dist_mag < NEAR_DIST) && (vtmp_mag < DB_VEL);

  assign target_in = cfg_data[POS_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      vel      <= '0;
      acc      <= '0;
      cruise   <= '0;
      target   <= '0;
      ts       <= TS_RESET;
      tick_reg <= 1'b0;
    end else begin
      if (start) begin
        tick_reg <= tick;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_TARGET: begin
            target <= target_in;
            cruise <= (target_in > pos) ? MAX_SPD : -MAX_SPD;
          end
          REG_TIME_STEP: begin
            ts <= cfg_data[TS_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (cw.brake && brake_hit) begin
        cruise <= '0;
      end
      if (cw.ld_acc) begin
        acc <= ACC_W'(acc_e);
      end
      if (cw.commit && tick_reg) begin
        pos <= POS_WIDTH'(psat);
        vel <= snap ? '0 : vtmp;
        if (snap) begin
          acc <= '0;
        end
      end
    end
  end

  // scratch and output word, no reset
  always_ff @(posedge clk) begin
    if (cw.ld_dist) begin
      gap <= DIST_W'(target) - DIST_W'(pos);
    end
    if (cw.mul_en) begin
      prod <= ma * mb;
    end
    if (cw.ld_vtmp) begin
      vtmp <= VEL_W'(vsat);
    end
    if (cw.commit) begin
      position_out <= tick_reg ? POS_WIDTH'(psat) : pos;
      velocity_out <= tick_reg ? (snap ? '0 : vtmp) : vel;
      accel_out    <= snap ? '0 : acc;
      braking      <= (cruise == '0);
      at_rest      <= snap;
    end
  end

endmodule

// ===== hdl/trapezoidal_motion_profiler.sv =====
// ----------------------------------------------------------------------------
// trapezoidal_motion_profiler
// Point-to-point trapezoidal velocity profile, one step per tick word.
// ----------------------------------------------------------------------------
// Sequencing: a tick-high word runs all seven steps from LOAD to COMMIT, a
//   tick-low word runs LOAD and then skips to COMMIT.
// Flow: one word at a time, with input stalled until the word commits; the
//   seven-step microprogram runs three products through one shared multiplier.
// Reset: position, velocity, acceleration, cruise speed and target clear,
//   time_step loads 6554 (0.1 s); results report braking 1 until a target write.
module trapezoidal_motion_profiler
  import tmprof_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int POS_WIDTH = POS_WIDTH_DEF,
  localparam int VEL_W = FRAC_BITS + 4,
  localparam int ACC_W = FRAC_BITS + 2,
  localparam int CFG_W = (POS_WIDTH > TS_W) ? POS_WIDTH : TS_W
)
(
  input  logic                        clk,
  input  logic                        rst,
  // input word
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        tick,
  // result word
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [POS_WIDTH-1:0] position_out,
  output logic signed [VEL_W-1:0]     velocity_out,
  output logic signed [ACC_W-1:0]     accel_out,
  output logic                        braking,
  output logic                        at_rest,
  // register writes
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data
);

  logic  busy;
  logic  start;
  logic  out_free;
  ctrl_t cw;
  stat_t stat;

  // One word in flight; the sequencer stalls input until its commit step.
  assign in_stall = busy;
  assign start    = in_valid & ~busy;

  // The output register doubles as the hand-off stage: commit waits only
  // while a previous result is still held and stalled.
  assign out_free = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Microcoded control: LOAD (dist, v*v), BRAKE, ACCEL, MULA (a*dt),
  // VEL (integrate + clamp), MULV (v*dt), COMMIT. Tick low skips to COMMIT.
  tmprof_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .stat     (stat),
    .busy     (busy),
    .cw       (cw)
  );

  tmprof_dp #(
    .FRAC_BITS (FRAC_BITS),
    .POS_WIDTH (POS_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .tick         (tick),
    .cw           (cw),
    .stat         (stat),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .position_out (position_out),
    .velocity_out (velocity_out),
    .accel_out    (accel_out),
    .braking      (braking),
    .at_rest      (at_rest)
  );

endmodule
